FILE: src/stftm_pkg.sv
// ----------------------------------------------------------------------------
// stftm_pkg: shared types, constants and twiddle tables
// Widths, register map, cell and sequencer codes, and the Q30 cos/sin tables
// used by the short-time magnitude spectrum block.
// ----------------------------------------------------------------------------
package stftm_pkg;

    localparam int FFT_SIZE  = 64;
    localparam int IDX_W     = $clog2(FFT_SIZE);
    localparam int NBINS     = FFT_SIZE / 2 + 1;

    localparam int CH_W      = 3;
    localparam int WL_W      = 7;
    localparam int HOP_W     = 13;
    localparam int SKIP_W    = 12;
    localparam int SAMPLE_W  = 16;
    localparam int BIN_W     = 6;
    localparam int MAG_W     = 21;
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;

    localparam int TW_W      = 32;
    localparam int PROD_W    = SAMPLE_W + TW_W;
    localparam int ACC_W     = PROD_W + IDX_W;
    localparam int RND_SHIFT = 22;
    localparam int MQ_W      = 30;
    localparam int SQ_W      = 2 * MQ_W;
    localparam int ROOT_W    = MQ_W;
    localparam int SQRT_ITERS = SQ_W / 2;
    localparam int CNT_W     = $clog2(SQRT_ITERS + 1);

    localparam logic [HOP_W-1:0] HOP_MAX = HOP_W'(4096);
    localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

    localparam logic [1:0] REG_CHANNEL = 2'd0;
    localparam logic [1:0] REG_WINDOW  = 2'd1;
    localparam logic [1:0] REG_HOP     = 2'd2;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_SHIFT
    } cell_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_ROUND,
        ST_SQUARE,
        ST_SUM,
        ST_SQRT,
        ST_OUT,
        ST_SLIDE
    } state_t;

    typedef logic signed [TW_W-1:0] tw_table_t [FFT_SIZE];

    // cos or sin of 2*pi*m/FFT_SIZE in Q30, octant reduction and Horner series
    function automatic logic signed [TW_W-1:0] twiddle(int m, bit want_sin);
        logic [63:0] q;
        logic [63:0] oct;
        logic [63:0] r;
        logic [63:0] a;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] c;
        logic [63:0] s;
        logic [63:0] one;
        logic [63:0] pi4;
        logic signed [63:0] co;
        logic signed [63:0] si;
        one = 64'd1 << 30;
        pi4 = 64'd843314857;
        q   = 64'(8 * m);
        oct = (q / 64'(FFT_SIZE)) & 64'd7;
        r   = q - oct * 64'(FFT_SIZE);
        a   = oct[0] ? (64'(FFT_SIZE) - r) : r;
        x   = (a * pi4) / 64'(FFT_SIZE);
        x2  = (x * x) >> 30;

        t = one - x2 / 64'd56;
        t = one - ((x2 * t) >> 30) / 64'd30;
        t = one - ((x2 * t) >> 30) / 64'd12;
        c = one - ((x2 * t) >> 30) / 64'd2;

        t = one - x2 / 64'd72;
        t = one - ((x2 * t) >> 30) / 64'd42;
        t = one - ((x2 * t) >> 30) / 64'd20;
        t = one - ((x2 * t) >> 30) / 64'd6;
        s = (x * t) >> 30;

        case (oct[2:0])
            3'd0:    begin co =  $signed(c); si =  $signed(s); end
            3'd1:    begin co =  $signed(s); si =  $signed(c); end
            3'd2:    begin co = -$signed(s); si =  $signed(c); end
            3'd3:    begin co = -$signed(c); si =  $signed(s); end
            3'd4:    begin co = -$signed(c); si = -$signed(s); end
            3'd5:    begin co = -$signed(s); si = -$signed(c); end
            3'd6:    begin co =  $signed(s); si = -$signed(c); end
            default: begin co =  $signed(c); si = -$signed(s); end
        endcase
        return want_sin ? si[TW_W-1:0] : co[TW_W-1:0];
    endfunction

    function automatic tw_table_t build_table(bit want_sin);
        tw_table_t tab;
        for (int i = 0; i < FFT_SIZE; i++)
        begin
            tab[i] = twiddle(i, want_sin);
        end
        return tab;
    endfunction

    localparam tw_table_t COS_TABLE = build_table(1'b0);
    localparam tw_table_t SIN_TABLE = build_table(1'b1);

endpackage

FILE: src/stftm_cell.sv
// ----------------------------------------------------------------------------
// stftm_cell: one window sample cell
// Holds one sample; loads a new sample or takes its neighbor's sample.
// ----------------------------------------------------------------------------
module stftm_cell
(
    input  logic                                   clk,
    input  stftm_pkg::cell_op_t                    op,
    input  logic signed [stftm_pkg::SAMPLE_W-1:0]  load_data,
    input  logic signed [stftm_pkg::SAMPLE_W-1:0]  nb_data,
    output logic signed [stftm_pkg::SAMPLE_W-1:0]  value
);

    logic signed [stftm_pkg::SAMPLE_W-1:0] value_reg;
    logic signed [stftm_pkg::SAMPLE_W-1:0] value_next;

    always_comb
    begin
        unique case (op)
            stftm_pkg::CELL_LOAD:  value_next = load_data;
            stftm_pkg::CELL_SHIFT: value_next = nb_data;
            default:               value_next = value_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

FILE: src/stftm_isqrt.sv
// ----------------------------------------------------------------------------
// stftm_isqrt: iterative integer square root
// Floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module stftm_isqrt
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [stftm_pkg::SQ_W-1:0]        value,
    output logic                              done,
    output logic [stftm_pkg::ROOT_W-1:0]      root
);

    logic [stftm_pkg::SQ_W-1:0]  v_reg,   v_next;
    logic [stftm_pkg::SQ_W-1:0]  res_reg, res_next;
    logic [stftm_pkg::SQ_W-1:0]  bit_reg, bit_next;
    logic [stftm_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [stftm_pkg::SQ_W-1:0]  trial;

    always_comb
    begin
        v_next    = v_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = res_reg + bit_reg;
        if (start)
        begin
            v_next    = value;
            res_next  = '0;
            bit_next  = stftm_pkg::SQ_W'(1) << (stftm_pkg::SQ_W - 2);
            cnt_next  = stftm_pkg::CNT_W'(stftm_pkg::SQRT_ITERS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (v_reg >= trial)
            begin
                v_next   = v_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == stftm_pkg::CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg[stftm_pkg::ROOT_W-1:0];

endmodule

FILE: src/stft_magnitude_spectrum.sv
// ----------------------------------------------------------------------------
// stft_magnitude_spectrum: short-time magnitude spectrum of one audio channel
// Sliding window over one channel of an interleaved stream, real DFT with a
// rectangular window, magnitudes of bins 0..FFT_SIZE/2 as the result stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one sample and its channel tag.
//   Samples of other channels are dropped. Once window_length samples of the
//   selected channel are held, the block computes one spectrum and sends
//   FFT_SIZE/2+1 items on the output channel (out_valid/out_ready), bin 0
//   first, last_bin set on the final bin. The window then advances by
//   hop_length samples.
//   A sample that does not complete a window is taken without blocking the
//   input. A sample that completes one blocks the input for the whole
//   spectrum: per bin, one multiply-accumulate per window sample through the
//   cell row, then rounding, squaring and an iterative square root, then the
//   output handshake; after the last bin the window slides by hop_length
//   shifts when the hop is shorter than the window.
//   Each bin waits in the output register until taken; a stalled receiver
//   holds the block. Reset clears the fill and skip counts and sets channel 0,
//   window 64, hop 32. A channel, window or hop write restarts collection.
// ----------------------------------------------------------------------------
module stft_magnitude_spectrum
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [stftm_pkg::SAMPLE_W-1:0]  sample,
    input  logic [stftm_pkg::CH_W-1:0]             channel,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [stftm_pkg::BIN_W-1:0]            bin_index,
    output logic [stftm_pkg::MAG_W-1:0]            magnitude,
    output logic                                   last_bin,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [stftm_pkg::ADDR_W-1:0]           paddr,
    input  logic [stftm_pkg::DATA_W-1:0]           pwdata,
    output logic [stftm_pkg::DATA_W-1:0]           prdata,
    output logic                                   pready
);

    localparam int N = stftm_pkg::FFT_SIZE;

    stftm_pkg::state_t state_reg, state_next;

    logic [stftm_pkg::CH_W-1:0]   chsel_reg, chsel_next;
    logic [stftm_pkg::WL_W-1:0]   wlen_reg,  wlen_next;
    logic [stftm_pkg::HOP_W-1:0]  hop_reg,   hop_next;
    logic [stftm_pkg::WL_W-1:0]   fill_reg,  fill_next;
    logic [stftm_pkg::SKIP_W-1:0] skip_reg,  skip_next;
    logic [stftm_pkg::BIN_W-1:0]  k_reg,     k_next;
    logic [stftm_pkg::IDX_W-1:0]  n_reg,     n_next;
    logic [stftm_pkg::IDX_W-1:0]  m_reg,     m_next;
    logic [stftm_pkg::WL_W-1:0]   slide_reg, slide_next;
    logic                         out_valid_reg, out_valid_next;
    logic [stftm_pkg::BIN_W-1:0]  bin_reg,   bin_next;
    logic [stftm_pkg::MAG_W-1:0]  mag_reg,   mag_next;
    logic                         last_reg,  last_next;
    logic                         pv_reg;

    logic signed [stftm_pkg::PROD_W-1:0] prod_re_reg, prod_im_reg;
    logic signed [stftm_pkg::ACC_W-1:0]  acc_re_reg,  acc_im_reg;
    logic [stftm_pkg::MQ_W-1:0]          ra_reg, ia_reg;
    logic [stftm_pkg::SQ_W-1:0]          sq_re_reg, sq_im_reg;

    logic [stftm_pkg::WL_W-1:0]   eff_wl;
    logic [stftm_pkg::HOP_W-1:0]  eff_hop;
    logic [stftm_pkg::WL_W-1:0]   wr_idx;
    logic [stftm_pkg::WL_W-1:0]   wl_last;
    logic                         cfg_wr;
    logic                         load_en;
    logic                         rotate;
    logic                         slide;
    logic                         start_bin;
    logic                         sqrt_start;
    logic                         sqrt_done;
    logic [stftm_pkg::ROOT_W-1:0] root;
    logic [stftm_pkg::ROOT_W:0]   mag_sum;
    logic [stftm_pkg::ROOT_W-8:0] mag_sh;
    logic [stftm_pkg::ACC_W-1:0]  re_abs, im_abs, re_rnd, im_rnd;

    logic signed [stftm_pkg::SAMPLE_W-1:0] cell_q  [N];
    logic signed [stftm_pkg::SAMPLE_W-1:0] cell_nb [N];
    stftm_pkg::cell_op_t                    cell_op [N];

    // effective window and hop after clamping
    always_comb
    begin
        if (wlen_reg == '0)
            eff_wl = stftm_pkg::WL_W'(1);
        else if (wlen_reg > stftm_pkg::WL_W'(N))
            eff_wl = stftm_pkg::WL_W'(N);
        else
            eff_wl = wlen_reg;
        if (hop_reg == '0)
            eff_hop = stftm_pkg::HOP_W'(1);
        else if (hop_reg > stftm_pkg::HOP_MAX)
            eff_hop = stftm_pkg::HOP_MAX;
        else
            eff_hop = hop_reg;
    end

    assign wl_last = eff_wl - 1'b1;
    assign wr_idx  = (fill_reg >= eff_wl) ? wl_last : fill_reg;
    assign cfg_wr  = psel & penable & pwrite;

    // cell row: rotate over the window during accumulation, shift on slide
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            if (i == N - 1)
                cell_nb[i] = cell_q[0];
            else
                cell_nb[i] = cell_q[(i + 1) % N];
            if (rotate && (stftm_pkg::WL_W'(i) == wl_last))
                cell_nb[i] = cell_q[0];
            cell_op[i] = stftm_pkg::CELL_HOLD;
            if (rotate || slide)
                cell_op[i] = stftm_pkg::CELL_SHIFT;
            if (load_en && (stftm_pkg::WL_W'(i) == wr_idx))
                cell_op[i] = stftm_pkg::CELL_LOAD;
        end
    end

    for (genvar g = 0; g < N; g++)
    begin : g_cell
        stftm_cell u_cell
        (
            .clk       (clk),
            .op        (cell_op[g]),
            .load_data (sample),
            .nb_data   (cell_nb[g]),
            .value     (cell_q[g])
        );
    end

    stftm_isqrt u_isqrt
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .value (sq_re_reg + sq_im_reg),
        .done  (sqrt_done),
        .root  (root)
    );

    always_comb
    begin
        mag_sum = {1'b0, root} + (stftm_pkg::ROOT_W + 1)'(128);
        mag_sh  = mag_sum[stftm_pkg::ROOT_W:8];
    end

    always_comb
    begin
        state_next     = state_reg;
        chsel_next     = chsel_reg;
        wlen_next      = wlen_reg;
        hop_next       = hop_reg;
        fill_next      = fill_reg;
        skip_next      = skip_reg;
        k_next         = k_reg;
        n_next         = n_reg;
        m_next         = m_reg;
        slide_next     = slide_reg;
        out_valid_next = out_valid_reg;
        bin_next       = bin_reg;
        mag_next       = mag_reg;
        last_next      = last_reg;
        load_en        = 1'b0;
        rotate         = 1'b0;
        slide          = 1'b0;
        start_bin      = 1'b0;
        sqrt_start     = 1'b0;
        in_ready       = (state_reg == stftm_pkg::ST_IDLE);

        unique case (state_reg)
            stftm_pkg::ST_IDLE:
            begin
                if (in_valid && (channel == chsel_reg))
                begin
                    if (skip_reg != '0)
                    begin
                        skip_next = skip_reg - 1'b1;
                    end
                    else
                    begin
                        load_en   = 1'b1;
                        fill_next = wr_idx + 1'b1;
                        if (wr_idx == wl_last)
                        begin
                            k_next     = '0;
                            start_bin  = 1'b1;
                            state_next = stftm_pkg::ST_MAC;
                        end
                    end
                end
            end
            stftm_pkg::ST_MAC:
            begin
                rotate = 1'b1;
                m_next = m_reg + k_reg[stftm_pkg::IDX_W-1:0];
                n_next = n_reg + 1'b1;
                if (stftm_pkg::WL_W'(n_reg) == wl_last)
                    state_next = stftm_pkg::ST_DRAIN;
            end
            stftm_pkg::ST_DRAIN:  state_next = stftm_pkg::ST_ROUND;
            stftm_pkg::ST_ROUND:  state_next = stftm_pkg::ST_SQUARE;
            stftm_pkg::ST_SQUARE: state_next = stftm_pkg::ST_SUM;
            stftm_pkg::ST_SUM:
            begin
                sqrt_start = 1'b1;
                state_next = stftm_pkg::ST_SQRT;
            end
            stftm_pkg::ST_SQRT:
            begin
                if (sqrt_done)
                begin
                    out_valid_next = 1'b1;
                    bin_next       = k_reg;
                    last_next      = (k_reg == stftm_pkg::BIN_W'(stftm_pkg::NBINS - 1));
                    mag_next       = (mag_sh > (stftm_pkg::ROOT_W - 7)'(stftm_pkg::MAG_MAX))
                                   ? stftm_pkg::MAG_MAX : mag_sh[stftm_pkg::MAG_W-1:0];
                    state_next     = stftm_pkg::ST_OUT;
                end
            end
            stftm_pkg::ST_OUT:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    if (last_reg)
                    begin
                        if (eff_hop >= stftm_pkg::HOP_W'(eff_wl))
                        begin
                            fill_next  = '0;
                            skip_next  = stftm_pkg::SKIP_W'(eff_hop - stftm_pkg::HOP_W'(eff_wl));
                            state_next = stftm_pkg::ST_IDLE;
                        end
                        else
                        begin
                            fill_next  = eff_wl - eff_hop[stftm_pkg::WL_W-1:0];
                            slide_next = eff_hop[stftm_pkg::WL_W-1:0];
                            state_next = stftm_pkg::ST_SLIDE;
                        end
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        start_bin  = 1'b1;
                        state_next = stftm_pkg::ST_MAC;
                    end
                end
            end
            stftm_pkg::ST_SLIDE:
            begin
                slide      = 1'b1;
                slide_next = slide_reg - 1'b1;
                if (slide_reg == stftm_pkg::WL_W'(1))
                    state_next = stftm_pkg::ST_IDLE;
            end
            default: state_next = stftm_pkg::ST_IDLE;
        endcase

        if (start_bin)
        begin
            n_next = '0;
            m_next = '0;
        end

        // a channel, window or hop register write restarts collection
        if (cfg_wr)
        begin
            unique case (paddr[3:2])
                stftm_pkg::REG_CHANNEL:
                begin
                    chsel_next = pwdata[stftm_pkg::CH_W-1:0];
                    fill_next  = '0;
                    skip_next  = '0;
                end
                stftm_pkg::REG_WINDOW:
                begin
                    wlen_next = pwdata[stftm_pkg::WL_W-1:0];
                    fill_next = '0;
                    skip_next = '0;
                end
                stftm_pkg::REG_HOP:
                begin
                    hop_next  = pwdata[stftm_pkg::HOP_W-1:0];
                    fill_next = '0;
                    skip_next = '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= stftm_pkg::ST_IDLE;
            chsel_reg     <= '0;
            wlen_reg      <= stftm_pkg::WL_W'(64);
            hop_reg       <= stftm_pkg::HOP_W'(32);
            fill_reg      <= '0;
            skip_reg      <= '0;
            k_reg         <= '0;
            n_reg         <= '0;
            m_reg         <= '0;
            slide_reg     <= '0;
            out_valid_reg <= 1'b0;
            pv_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chsel_reg     <= chsel_next;
            wlen_reg      <= wlen_next;
            hop_reg       <= hop_next;
            fill_reg      <= fill_next;
            skip_reg      <= skip_next;
            k_reg         <= k_next;
            n_reg         <= n_next;
            m_reg         <= m_next;
            slide_reg     <= slide_next;
            out_valid_reg <= out_valid_next;
            pv_reg        <= (state_reg == stftm_pkg::ST_MAC);
        end
    end

    // rounding of |Re| and |Im| to Q8
    always_comb
    begin
        re_abs = acc_re_reg[stftm_pkg::ACC_W-1] ? stftm_pkg::ACC_W'(-acc_re_reg)
                                                : stftm_pkg::ACC_W'(acc_re_reg);
        im_abs = acc_im_reg[stftm_pkg::ACC_W-1] ? stftm_pkg::ACC_W'(-acc_im_reg)
                                                : stftm_pkg::ACC_W'(acc_im_reg);
        re_rnd = re_abs + (stftm_pkg::ACC_W'(1) << (stftm_pkg::RND_SHIFT - 1));
        im_rnd = im_abs + (stftm_pkg::ACC_W'(1) << (stftm_pkg::RND_SHIFT - 1));
    end

    always_ff @(posedge clk)
    begin
        bin_reg     <= bin_next;
        mag_reg     <= mag_next;
        last_reg    <= last_next;
        prod_re_reg <= cell_q[0] * stftm_pkg::COS_TABLE[m_reg];
        prod_im_reg <= cell_q[0] * stftm_pkg::SIN_TABLE[m_reg];
        if (start_bin)
        begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end
        else if (pv_reg)
        begin
            acc_re_reg <= acc_re_reg + stftm_pkg::ACC_W'(prod_re_reg);
            acc_im_reg <= acc_im_reg + stftm_pkg::ACC_W'(prod_im_reg);
        end
        ra_reg    <= re_rnd[stftm_pkg::RND_SHIFT +: stftm_pkg::MQ_W];
        ia_reg    <= im_rnd[stftm_pkg::RND_SHIFT +: stftm_pkg::MQ_W];
        sq_re_reg <= ra_reg * ra_reg;
        sq_im_reg <= ia_reg * ia_reg;
    end

    always_comb
    begin
        unique case (paddr[3:2])
            stftm_pkg::REG_CHANNEL: prdata = stftm_pkg::DATA_W'(chsel_reg);
            stftm_pkg::REG_WINDOW:  prdata = stftm_pkg::DATA_W'(wlen_reg);
            stftm_pkg::REG_HOP:     prdata = stftm_pkg::DATA_W'(hop_reg);
            default:                prdata = '0;
        endcase
    end

    assign pready    = 1'b1;
    assign out_valid = out_valid_reg;
    assign bin_index = bin_reg;
    assign magnitude = mag_reg;
    assign last_bin  = last_reg;

endmodule

FILE: src/stftm_checker.sv
// ----------------------------------------------------------------------------
// stftm_checker: port-level checks for the magnitude spectrum block
// Watches the handshakes and the last-bin flag on the top-level ports.
// ----------------------------------------------------------------------------
module stftm_checker
(
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_ready,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic [stftm_pkg::BIN_W-1:0]        bin_index,
    input logic [stftm_pkg::MAG_W-1:0]        magnitude,
    input logic                               last_bin
);

    // hold a stalled item
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(bin_index) && $stable(magnitude))
        else $error("output item changed while stalled");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_bin == (bin_index == stftm_pkg::BIN_W'(stftm_pkg::NBINS - 1))))
        else $error("last_bin does not match final bin");

    a_no_input_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input open while spectrum in flight");

    a_more_bins: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_bin |=> !in_ready)
        else $error("input reopened before spectrum finished");

endmodule

bind stft_magnitude_spectrum stftm_checker u_stftm_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .bin_index (bin_index),
    .magnitude (magnitude),
    .last_bin  (last_bin)
);

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for stft_magnitude_spectrum
// Drives a directed table and random phases of tagged samples. Register
// writes go through the APB-style port. A built-in predictor computes every
// spectrum bin; each accepted item is checked against it or a typed value.
// ----------------------------------------------------------------------------
module testbench;

    localparam int LIMIT_CYCLES = 8000000;
    localparam int SETTLE_CYCLES = 5000;
    localparam int LONG_HOLD = 20000;
    localparam logic [1:0] REG_SPARE = 2'd3;

    typedef enum logic { ROW_WRITE, ROW_SAMPLE } row_kind_t;

    typedef struct {
        row_kind_t    kind;
        logic [1:0]   reg_idx;
        logic [31:0]  value;
        int           reps;
        logic [2:0]   ch;
        bit           has_mag;
        logic [20:0]  mag;
    } stim_row_t;

    typedef struct {
        logic [5:0]   bin;
        logic [20:0]  mag;
        logic         last;
    } bin_item_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    logic signed [15:0]             sample = '0;
    logic [2:0]                     channel = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic [5:0]                     bin_index;
    logic [20:0]                    magnitude;
    logic                           last_bin;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [stftm_pkg::ADDR_W-1:0]   paddr = '0;
    logic [31:0]                    pwdata = '0;
    logic [31:0]                    prdata;
    logic                           pready;

    stft_magnitude_spectrum u_top (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state
    bin_item_t   spectrum_q[$];
    int          win_buf[stftm_pkg::FFT_SIZE];
    int unsigned fill_cnt;
    int unsigned skip_cnt;
    int unsigned sel_ch;
    int unsigned win_len;
    int unsigned hop_len;
    longint      cos_q30[stftm_pkg::FFT_SIZE];
    longint      sin_q30[stftm_pkg::FFT_SIZE];

    int          errors = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          hold_token = 0;
    int          seen_token = 0;
    int          hold_left = 0;
    longint      cycles = 0;

    function automatic void make_twiddle(int m, output longint co, output longint si);
        longint unsigned q, oct, r, a, x, x2, t, c, s, one;
        one = 64'd1 << 30;
        q   = 8 * m;
        oct = (q / stftm_pkg::FFT_SIZE) & 7;
        r   = q - oct * stftm_pkg::FFT_SIZE;
        a   = (oct & 1) ? (stftm_pkg::FFT_SIZE - r) : r;
        x   = (a * 64'd843314857) / stftm_pkg::FFT_SIZE;
        x2  = (x * x) >> 30;
        t = one - x2 / 56;
        t = one - ((x2 * t) >> 30) / 30;
        t = one - ((x2 * t) >> 30) / 12;
        c = one - ((x2 * t) >> 30) / 2;
        t = one - x2 / 72;
        t = one - ((x2 * t) >> 30) / 42;
        t = one - ((x2 * t) >> 30) / 20;
        t = one - ((x2 * t) >> 30) / 6;
        s = (x * t) >> 30;
        case (oct)
            0: begin co =  c; si =  s; end
            1: begin co =  s; si =  c; end
            2: begin co = -s; si =  c; end
            3: begin co = -c; si =  s; end
            4: begin co = -c; si = -s; end
            5: begin co = -s; si = -c; end
            6: begin co =  s; si = -c; end
            default: begin co = c; si = -s; end
        endcase
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned round_abs(longint v);
        longint unsigned u;
        u = (v < 0) ? longint'(-v) : v;
        return (u + (64'd1 << 21)) >> 22;
    endfunction

    function automatic void push_spectrum(int unsigned wl);
        longint re, im;
        longint unsigned ra, ia, mg;
        bin_item_t it;
        for (int k = 0; k < stftm_pkg::NBINS; k++)
        begin
            re = 0;
            im = 0;
            for (int n = 0; n < wl; n++)
            begin
                re += longint'(win_buf[n]) * cos_q30[(k * n) % stftm_pkg::FFT_SIZE];
                im += longint'(win_buf[n]) * sin_q30[(k * n) % stftm_pkg::FFT_SIZE];
            end
            ra = round_abs(re);
            ia = round_abs(im);
            mg = (int_sqrt(ra * ra + ia * ia) + 128) >> 8;
            if (mg > 2097151)
                mg = 2097151;
            it.bin  = k[5:0];
            it.mag  = mg[20:0];
            it.last = (k == stftm_pkg::NBINS - 1);
            spectrum_q.push_back(it);
        end
    endfunction

    // returns the number of bins the item causes
    function automatic int predict_sample(logic signed [15:0] s, logic [2:0] ch);
        int unsigned wl, hop;
        wl  = (win_len == 0) ? 1 : (win_len > stftm_pkg::FFT_SIZE) ? stftm_pkg::FFT_SIZE
                                                                   : win_len;
        hop = (hop_len == 0) ? 1 : (hop_len > 4096) ? 4096 : hop_len;
        if (ch != sel_ch)
            return 0;
        if (skip_cnt != 0)
        begin
            skip_cnt--;
            return 0;
        end
        if (fill_cnt >= wl)
            fill_cnt = wl - 1;
        win_buf[fill_cnt] = s;
        fill_cnt++;
        if (fill_cnt < wl)
            return 0;
        push_spectrum(wl);
        if (hop >= wl)
        begin
            fill_cnt = 0;
            skip_cnt = (hop - wl) & 12'hFFF;
        end
        else
        begin
            for (int i = 0; i + hop < wl; i++)
                win_buf[i] = win_buf[i + hop];
            fill_cnt = wl - hop;
        end
        return stftm_pkg::NBINS;
    endfunction

    function automatic void predict_write(logic [1:0] idx, logic [31:0] v);
        case (idx)
            stftm_pkg::REG_CHANNEL: sel_ch  = v & 7;
            stftm_pkg::REG_WINDOW:  win_len = v & 127;
            stftm_pkg::REG_HOP:     hop_len = v & 8191;
            default:                return;
        endcase
        fill_cnt = 0;
        skip_cnt = 0;
    endfunction

    task automatic send_sample(logic signed [15:0] s, logic [2:0] ch, output int nbins);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= s;
        channel  <= ch;
        do
            @(posedge clk);
        while (!in_ready);
        nbins = predict_sample(s, ch);
    endtask

    // hold the port idle until every bin is out, then let the block settle
    task automatic drain_block();
        in_valid <= 1'b0;
        while (spectrum_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] v);
        drain_block();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        predict_write(idx, v);
    endtask

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'(int'($urandom_range(0, 15)) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic run_phase(int ch, int wl, int hop, int mode, int items, bit pressure);
        int nb;
        write_reg(stftm_pkg::REG_CHANNEL, ch);
        write_reg(stftm_pkg::REG_WINDOW, wl);
        write_reg(stftm_pkg::REG_HOP, hop);
        case (mode)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 83; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 83; end
            default: begin idle_pct = 9; stall_pct = 9; end
        endcase
        if (pressure)
            hold_token++;
        for (int i = 0; i < items; i++)
        begin
            // mostly the selected channel, the rest goes to a random channel
            if ($urandom_range(0, 99) < 80)
                send_sample(rand_sample(), 3'(ch), nb);
            else
                send_sample(rand_sample(), 3'($urandom), nb);
        end
        idle_pct = 0;
        stall_pct = 0;
    endtask

    stim_row_t directed[] = '{
        '{ROW_SAMPLE, REG_SPARE,              0,      1, 3'd1, 0, 0},
        '{ROW_WRITE,  stftm_pkg::REG_CHANNEL, 1,      0, 3'd0, 0, 0},
        '{ROW_WRITE,  stftm_pkg::REG_WINDOW,  1,      0, 3'd0, 0, 0},
        '{ROW_WRITE,  stftm_pkg::REG_HOP,     1,      0, 3'd0, 0, 0},
        '{ROW_SAMPLE, REG_SPARE,              32767,  1, 3'd1, 1, 21'd32767},
        '{ROW_SAMPLE, REG_SPARE,              -32768, 1, 3'd1, 1, 21'd32768},
        '{ROW_SAMPLE, REG_SPARE,              0,      1, 3'd1, 1, 21'd0},
        '{ROW_SAMPLE, REG_SPARE,              123,    1, 3'd2, 0, 0},
        '{ROW_WRITE,  REG_SPARE,              5,      0, 3'd0, 0, 0},
        '{ROW_SAMPLE, REG_SPARE,              -1,     1, 3'd1, 1, 21'd1},
        '{ROW_WRITE,  stftm_pkg::REG_WINDOW,  0,      0, 3'd0, 0, 0},
        '{ROW_SAMPLE, REG_SPARE,              100,    1, 3'd1, 1, 21'd100},
        '{ROW_WRITE,  stftm_pkg::REG_HOP,     0,      0, 3'd0, 0, 0},
        '{ROW_SAMPLE, REG_SPARE,              -7,     1, 3'd1, 1, 21'd7},
        '{ROW_WRITE,  stftm_pkg::REG_HOP,     3,      0, 3'd0, 0, 0},
        '{ROW_SAMPLE, REG_SPARE,              9,      1, 3'd1, 1, 21'd9},
        '{ROW_SAMPLE, REG_SPARE,              50,     2, 3'd1, 0, 0},
        '{ROW_SAMPLE, REG_SPARE,              -9,     1, 3'd1, 1, 21'd9},
        '{ROW_WRITE,  stftm_pkg::REG_WINDOW,  127,    0, 3'd0, 0, 0},
        '{ROW_WRITE,  stftm_pkg::REG_HOP,     8191,   0, 3'd0, 0, 0},
        '{ROW_SAMPLE, REG_SPARE,              -32768, 64, 3'd1, 0, 0},
        '{ROW_SAMPLE, REG_SPARE,              777,    3, 3'd1, 0, 0},
        '{ROW_WRITE,  stftm_pkg::REG_WINDOW,  3,      0, 3'd0, 0, 0},
        '{ROW_WRITE,  stftm_pkg::REG_HOP,     2,      0, 3'd0, 0, 0},
        '{ROW_SAMPLE, REG_SPARE,              32767,  5, 3'd1, 0, 0}
    };

    initial
    begin
        int nb;
        for (int m = 0; m < stftm_pkg::FFT_SIZE; m++)
            make_twiddle(m, cos_q30[m], sin_q30[m]);
        sel_ch = 0;
        win_len = 64;
        hop_len = 32;
        fill_cnt = 0;
        skip_cnt = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[r])
        begin
            if (directed[r].kind == ROW_WRITE)
                write_reg(directed[r].reg_idx, directed[r].value);
            else
            begin
                for (int j = 0; j < directed[r].reps; j++)
                begin
                    send_sample(directed[r].value[15:0], directed[r].ch, nb);
                    // typed value replaces the predicted one on every bin
                    if (directed[r].has_mag)
                        for (int b = spectrum_q.size() - nb; b < spectrum_q.size(); b++)
                            spectrum_q[b].mag = directed[r].mag;
                end
            end
        end

        run_phase(3, 64, 32, 0, 80, 1'b0);
        run_phase(5, 8, 3, 1, 30, 1'b0);
        run_phase(7, 16, 16, 2, 30, 1'b0);
        run_phase(0, 1, 1, 3, 30, 1'b0);
        run_phase(6, 6, 2, 0, 40, 1'b1);
        run_phase(2, 4, 20, 3, 25, 1'b0);
        run_phase(4, 33, 1, 0, 45, 1'b0);
        drain_block();

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_token != seen_token)
        begin
            seen_token <= hold_token;
            hold_left  <= LONG_HOLD;
            out_ready  <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        bin_item_t exp_bin;
        if (rst_n && out_valid && out_ready)
        begin
            if (spectrum_q.size() == 0)
            begin
                $error("unexpected bin item: bin_index %0d magnitude %0d", bin_index, magnitude);
                errors++;
            end
            else
            begin
                exp_bin = spectrum_q.pop_front();
                if (bin_index !== exp_bin.bin)
                begin
                    $error("bin_index: expected %0d, got %0d", exp_bin.bin, bin_index);
                    errors++;
                end
                if (magnitude !== exp_bin.mag)
                begin
                    $error("magnitude: expected %0d, got %0d", exp_bin.mag, magnitude);
                    errors++;
                end
                if (last_bin !== exp_bin.last)
                begin
                    $error("last_bin: expected %0d, got %0d", exp_bin.last, last_bin);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("Verification failed");
            $finish;
        end
    end

endmodule
